// File: rtl/core/cce_pkg.sv
// Shared types and constants for the configurable CRC engine.
package cce_pkg;

    // Fixed field widths of the stream and configuration payloads
    localparam int CRC_FIELD_W = 64;
    localparam int DATA_W      = 8;
    localparam int COUNT_W     = 4;
    localparam int WIDTH_W     = 7;
    localparam int CFG_IDX_W   = 3;

    // Slave tdata layout, lowest bit first
    localparam int S_START_LSB = 0;
    localparam int S_DATA_LSB  = S_START_LSB + CRC_FIELD_W;
    localparam int S_COUNT_LSB = S_DATA_LSB + DATA_W;
    localparam int S_EXP_LSB   = S_COUNT_LSB + COUNT_W;
    localparam int S_FIELDS_W  = S_EXP_LSB + CRC_FIELD_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = CRC_FIELD_W;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRC_WIDTH      = 3'd0,
        CFG_POLYNOMIAL     = 3'd1,
        CFG_FINAL_XOR      = 3'd2,
        CFG_REFLECT_INPUT  = 3'd3,
        CFG_REFLECT_OUTPUT = 3'd4
    } cfg_reg_t;

    // Per-item control for the bit feeder
    typedef struct packed {
        logic               reflect;
        logic [COUNT_W-1:0] bit_count;
    } feed_ctrl_t;

endpackage

// File: rtl/core/cce_feed.sv
// Unrolled bit feeder: up to BITS_PER_ITEM CRC division steps on an MSB-aligned remainder.
module cce_feed
    import cce_pkg::*;
#(
    parameter int MAX_WIDTH     = 64,
    parameter int BITS_PER_ITEM = 8
)
(
    input  logic [MAX_WIDTH-1:0] rem_in,
    input  logic [MAX_WIDTH-1:0] poly_al,
    input  logic [DATA_W-1:0]    data,
    input  feed_ctrl_t           ctrl,
    output logic [MAX_WIDTH-1:0] rem_out
);

    localparam logic [COUNT_W-1:0] BPI_C = COUNT_W'(BITS_PER_ITEM);

    logic [MAX_WIDTH-1:0] acc;
    logic [COUNT_W-1:0]   count_eff;
    logic                 bit_in;
    logic                 step_en;
    logic                 fb;

    // Top bit of the remainder always sits at the MSB; low bits below the
    // CRC width stay zero because the polynomial is aligned the same way.
    always_comb
    begin
        count_eff = (ctrl.bit_count > BPI_C) ? BPI_C : ctrl.bit_count;
        acc       = rem_in;
        bit_in    = 1'b0;
        step_en   = 1'b0;
        fb        = 1'b0;
        for (int i = 0; i < BITS_PER_ITEM; i++)
        begin
            if (ctrl.reflect)
            begin
                bit_in  = data[BITS_PER_ITEM-1-i];
                step_en = 1'b1;
            end
            else
            begin
                bit_in  = data[i];
                step_en = (COUNT_W'(i) < count_eff);
            end
            fb = acc[MAX_WIDTH-1] ^ bit_in;
            if (step_en)
            begin
                acc = (acc << 1) ^ (fb ? poly_al : '0);
            end
        end
        rem_out = acc;
    end

endmodule

// File: rtl/core/configurable_crc_engine.sv
// Top level of the configurable CRC engine: stream ports, configuration and result stage.
//
// Streaming CRC engine of configurable width (1 to MAX_WIDTH bits), polynomial, final
// XOR, input reflection and output reflection. Each slave transaction carries up to
// BITS_PER_ITEM message bits; setting tuser (first) loads start_value as the initial
// remainder before the chunk's bits are fed. Forward mode feeds bit 0 upward for
// bit_count bits; input reflection feeds all bits from the top one down. A transaction
// with tlast set produces one master transaction holding the finished checksum and a
// match flag against check_value; other transactions produce nothing. The engine
// takes one transaction per clock unless a held result backs up the pipeline: the whole
// chunk is folded into the remainder by an unrolled chain of BITS_PER_ITEM conditional
// XOR steps, and that chain, feeding the remainder register back to itself, sets the
// rate. A last transaction passes the input register, the remainder stage and the result
// register before m_tvalid rises. Write configuration only while the engine is
// idle; a crc_width write realigns the stored remainder in the same cycle unless an
// item enters the remainder stage, and the aligned polynomial is re-registered from
// the stored polynomial and width after any write. No clearing pass after reset is needed.
module configurable_crc_engine
    import cce_pkg::*;
#(
    parameter int MAX_WIDTH     = 64,
    parameter int BITS_PER_ITEM = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // slave stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // start_value[63:0], data_byte[71:64],
                                              // bit_count[75:72], check_value[139:76]
    input  logic [0:0]             s_tuser,   // first[0]
    input  logic                   s_tlast,   // last
    // master stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // crc_value[63:0]
    output logic [0:0]             m_tuser,   // matches_res[0]
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CRC_FIELD_W-1:0] cfg_data
);

    localparam int SHIFT_W   = $clog2(MAX_WIDTH);
    localparam int RESET_W   = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;
    localparam logic [SHIFT_W-1:0]   RESET_SHIFT = SHIFT_W'(MAX_WIDTH - RESET_W);
    localparam logic [MAX_WIDTH-1:0] ONES        = '1;
    localparam logic [MAX_WIDTH-1:0] RESET_POLY  = MAX_WIDTH'(64'h0000_0000_04C1_1DB7);
    localparam logic [WIDTH_W-1:0]   MAX_W_C     = WIDTH_W'(MAX_WIDTH);

    // ------------------------------------------------------------------
    // Configuration registers. The CRC is kept MSB-aligned in a MAX_WIDTH
    // word; shift_reg is MAX_WIDTH minus the effective width.
    // ------------------------------------------------------------------
    logic [SHIFT_W-1:0]   shift_reg;
    logic [MAX_WIDTH-1:0] mask_reg;
    logic [MAX_WIDTH-1:0] poly_reg;
    logic [MAX_WIDTH-1:0] poly_al_reg;
    logic [MAX_WIDTH-1:0] final_xor_reg;
    logic                 reflect_in_reg;
    logic                 reflect_out_reg;

    logic [WIDTH_W-1:0]   width_eff;
    logic [SHIFT_W-1:0]   shift_next;
    logic                 cfg_write;
    logic                 cfg_width_write;

    assign cfg_ready       = 1'b1;
    assign cfg_write       = cfg_valid & cfg_ready;
    assign cfg_width_write = cfg_write & (cfg_reg_t'(cfg_index) == CFG_CRC_WIDTH);

    // Clamp the requested width into 1..MAX_WIDTH
    always_comb
    begin
        if (cfg_data[WIDTH_W-1:0] == '0)
        begin
            width_eff = WIDTH_W'(1);
        end
        else if (cfg_data[WIDTH_W-1:0] > MAX_W_C)
        begin
            width_eff = MAX_W_C;
        end
        else
        begin
            width_eff = cfg_data[WIDTH_W-1:0];
        end
        shift_next = SHIFT_W'(MAX_W_C - width_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg       <= RESET_SHIFT;
            mask_reg        <= ONES >> RESET_SHIFT;
            poly_reg        <= RESET_POLY;
            poly_al_reg     <= RESET_POLY << RESET_SHIFT;
            final_xor_reg   <= '0;
            reflect_in_reg  <= 1'b0;
            reflect_out_reg <= 1'b0;
        end
        else
        begin
            // Track the aligned polynomial, registered from the stored poly_reg and shift_reg
            poly_al_reg <= poly_reg << shift_reg;
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_CRC_WIDTH:
                    begin
                        shift_reg <= shift_next;
                        mask_reg  <= ONES >> shift_next;
                    end
                    CFG_POLYNOMIAL:     poly_reg        <= cfg_data[MAX_WIDTH-1:0];
                    CFG_FINAL_XOR:      final_xor_reg   <= cfg_data[MAX_WIDTH-1:0];
                    CFG_REFLECT_INPUT:  reflect_in_reg  <= cfg_data[0];
                    CFG_REFLECT_OUTPUT: reflect_out_reg <= cfg_data[0];
                    default:            ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register (s1), remainder stage (s2),
    // result register. Non-last items drop out of s2 without a result.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s2_last_reg;
    logic m_valid_reg;

    logic out_free;
    logic s2_go;
    logic s1_go;
    logic s_accept;
    logic s1_move;
    logic out_load;

    assign out_free = !m_valid_reg || m_tready;
    assign s2_go    = !s2_valid_reg || !s2_last_reg || out_free;
    assign s1_go    = !s1_valid_reg || s2_go;
    assign s_tready = s1_go;
    assign s_accept = s_tvalid & s_tready;
    assign s1_move  = s1_valid_reg & s2_go;
    assign out_load = s2_valid_reg & s2_last_reg & out_free;

    // s1 payload
    logic                   s1_first_reg;
    logic [MAX_WIDTH-1:0]   s1_start_reg;
    logic [DATA_W-1:0]      s1_data_reg;
    logic [COUNT_W-1:0]     s1_count_reg;
    logic                   s1_last_reg;
    logic [CRC_FIELD_W-1:0] s1_expected_reg;

    // s2 payload; its remainder is remainder_reg itself
    logic [CRC_FIELD_W-1:0] s2_expected_reg;

    // Stored remainder, MSB-aligned, bits below the CRC width kept zero
    logic [MAX_WIDTH-1:0]   remainder_reg;
    logic [MAX_WIDTH-1:0]   remainder_next;
    logic [MAX_WIDTH-1:0]   rem_start;
    logic [MAX_WIDTH-1:0]   rem_realigned;
    feed_ctrl_t             feed_ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end
        else
        begin
            if (s1_go)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_go)
            begin
                s2_valid_reg <= s1_valid_reg;
                s2_last_reg  <= s1_last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_first_reg    <= s_tuser[0];
            s1_start_reg    <= s_tdata[S_START_LSB +: MAX_WIDTH];
            s1_data_reg     <= s_tdata[S_DATA_LSB +: DATA_W];
            s1_count_reg    <= s_tdata[S_COUNT_LSB +: COUNT_W];
            s1_last_reg     <= s_tlast;
            s1_expected_reg <= s_tdata[S_EXP_LSB +: CRC_FIELD_W];
        end
        if (s1_move)
        begin
            s2_expected_reg <= s1_expected_reg;
        end
    end

    // Left shift into alignment also truncates bits above the CRC width
    assign rem_start = s1_first_reg ? (s1_start_reg << shift_reg) : remainder_reg;
    assign feed_ctrl = '{reflect: reflect_in_reg, bit_count: s1_count_reg};

    // Width change keeps the remainder's value, masked to the new width
    assign rem_realigned = (remainder_reg >> shift_reg) << shift_next;

    cce_feed #(
        .MAX_WIDTH     (MAX_WIDTH),
        .BITS_PER_ITEM (BITS_PER_ITEM)
    ) u_feed (
        .rem_in  (rem_start),
        .poly_al (poly_al_reg),
        .data    (s1_data_reg),
        .ctrl    (feed_ctrl),
        .rem_out (remainder_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remainder_reg <= '0;
        end
        else if (s1_move)
        begin
            remainder_reg <= remainder_next;
        end
        else if (cfg_width_write)
        begin
            remainder_reg <= rem_realigned;
        end
    end

    // ------------------------------------------------------------------
    // Finish: reflect or right-align, XOR, mask, compare
    // ------------------------------------------------------------------
    logic [MAX_WIDTH-1:0]   rem_rev;
    logic [MAX_WIDTH-1:0]   rem_pick;
    logic [MAX_WIDTH-1:0]   crc_sum;
    logic [CRC_FIELD_W-1:0] crc_value_next;
    logic                   matches_next;
    logic [M_TDATA_W-1:0]   crc_value_reg;
    logic                   matches_res_reg;

    // Reversing the aligned word reverses the CRC within its width
    always_comb
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            rem_rev[i] = remainder_reg[MAX_WIDTH-1-i];
        end
        rem_pick       = reflect_out_reg ? rem_rev : (remainder_reg >> shift_reg);
        crc_sum        = (rem_pick ^ final_xor_reg) & mask_reg;
        crc_value_next = CRC_FIELD_W'(crc_sum);
        matches_next   = (crc_value_next == s2_expected_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            crc_value_reg   <= crc_value_next;
            matches_res_reg <= matches_next;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = crc_value_reg;
    assign m_tuser[0] = matches_res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A result appears only from a last item leaving the remainder stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(s2_valid_reg && s2_last_reg))
        else $error("result raised without a last item in the remainder stage");

    // A last item held in s2 must keep its remainder until it is finished
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_last_reg && !out_free && !cfg_valid) |=> $stable(remainder_reg))
        else $error("remainder changed while a pending result waited");

    // Backpressure on the slave side only with a full input register
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s2_valid_reg && s2_last_reg && m_valid_reg))
        else $error("slave stalled with room in the pipeline");

endmodule

// File: test/tb_configurable_crc_engine.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the configurable CRC engine with its own checksum predictor.
module tb_configurable_crc_engine;
    import cce_pkg::*;

    localparam int NUM_PHASES   = 14;
    localparam int PHASE_ITEMS  = 82;
    localparam int DRAIN_CYCLES = 8;    // three-stage pipeline plus margin
    localparam int HOLD_CYCLES  = 300;  // long receiver hold-off that backs up the engine

    // One input chunk: the tdata fields in their tdata order, plus first (tuser) and last (tlast)
    typedef struct packed {
        logic                   first;
        logic [CRC_FIELD_W-1:0] start_value;
        logic [DATA_W-1:0]      data_byte;
        logic [COUNT_W-1:0]     bit_count;
        logic                   last;
        logic [CRC_FIELD_W-1:0] check_value;
    } chunk_t;

    // One finished checksum as the master side reports it
    typedef struct packed {
        logic [CRC_FIELD_W-1:0] crc_value;
        logic                   matches_res;
    } checksum_t;

    // Directed row: the chunk, and a hand-typed checksum when pinned is set
    typedef struct packed {
        chunk_t    chunk;
        logic      pinned;
        checksum_t pin;
    } probe_row_t;

    // Directed rows run with the reset settings: width 32, poly 04C11DB7, no XOR, no reflection.
    // Columns: {first, start_value, data_byte, bit_count, last, check_value}, pinned, pin
    localparam probe_row_t DIRECTED [14] = '{
        // all-zero byte from a zero start stays zero
        '{'{1'b1, 64'h0, 8'h00, 4'd8, 1'b1, 64'h0}, 1'b1, '{64'h0, 1'b1}},
        // a single set bit from a zero start leaves exactly the polynomial
        '{'{1'b1, 64'h0, 8'h01, 4'd1, 1'b1, 64'h04C11DB7}, 1'b1, '{64'h04C11DB7, 1'b1}},
        // zero bit count feeds nothing; start value is cut to the CRC width
        '{'{1'b1, '1, 8'hFF, 4'd0, 1'b1, 64'hFFFFFFFF}, 1'b1, '{64'hFFFFFFFF, 1'b1}},
        // expected value with bits above the width never matches
        '{'{1'b1, '1, 8'h00, 4'd0, 1'b1, '1}, 1'b1, '{64'hFFFFFFFF, 1'b0}},
        // bit count above eight feeds eight bits
        '{'{1'b1, 64'h0, 8'hFF, 4'd15, 1'b0, 64'h0}, 1'b0, '0},
        // no first: continue from the remainder, start value ignored
        '{'{1'b0, 64'hDEADBEEF_CAFEF00D, 8'h5A, 4'd8, 1'b0, '0}, 1'b0, '0},
        '{'{1'b0, 64'h0, 8'h00, 4'd9, 1'b1, 64'hFFFFFFFF_00000000}, 1'b0, '0},
        '{'{1'b1, 64'h12345678, 8'h80, 4'd8, 1'b1, '0}, 1'b0, '0},
        // no first right after a finished message keeps folding into the old remainder
        '{'{1'b0, '1, 8'hC3, 4'd3, 1'b1, 64'hA5A5A5A5_5A5A5A5A}, 1'b0, '0},
        '{'{1'b1, '1, 8'hFF, 4'd8, 1'b0, '0}, 1'b0, '0},
        // first in mid-message drops everything folded so far
        '{'{1'b1, 64'h0, 8'h00, 4'd8, 1'b1, 64'h0}, 1'b1, '{64'h0, 1'b1}},
        '{'{1'b1, 64'h0, 8'hFF, 4'd7, 1'b0, '0}, 1'b0, '0},
        '{'{1'b0, 64'h0, 8'h7F, 4'd2, 1'b0, '0}, 1'b0, '0},
        '{'{1'b0, 64'h0, 8'hAA, 4'd4, 1'b1, '1}, 1'b0, '0}
    };

    // Phase widths: the extremes 0, 1, 64 and 127 among ordinary ones
    localparam logic [WIDTH_W-1:0] PHASE_WIDTH [NUM_PHASES] = '{
        7'd8, 7'd16, 7'd64, 7'd1, 7'd0, 7'd127, 7'd32,
        7'd5, 7'd12, 7'd24, 7'd40, 7'd63, 7'd64, 7'd3
    };

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CRC_FIELD_W-1:0] cfg_data  = '0;

    // Predictor copy of the engine settings and the running remainder
    logic [WIDTH_W-1:0]     cfg_crc_width = 7'd32;
    logic [CRC_FIELD_W-1:0] cfg_poly      = 64'h04C11DB7;
    logic [CRC_FIELD_W-1:0] cfg_fxor      = '0;
    logic                   cfg_rin       = 1'b0;
    logic                   cfg_rout      = 1'b0;
    logic [CRC_FIELD_W-1:0] crc_acc       = '0;

    checksum_t checksum_q [$];   // checksums still owed by the engine, oldest first
    checksum_t rx_want;
    int        fail_count      = 0;
    int        sender_idle_pct = 0;
    int        rx_stall_pct    = 0;
    bit        hold_go         = 1'b0;
    logic      rx_hold         = 1'b0;

    configurable_crc_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Width the engine really uses: zero acts as one, anything past 64 as 64
    function automatic int unsigned active_width();
        if (cfg_crc_width == 0)
            return 1;
        if (cfg_crc_width > 64)
            return 64;
        return cfg_crc_width;
    endfunction

    function automatic logic [63:0] lane_mask(input int unsigned w);
        return (w >= 64) ? {64{1'b1}} : ((64'd1 << w) - 64'd1);
    endfunction

    // Push one message bit into the top of the remainder, then divide
    function automatic logic [63:0] shift_in_bit(input logic [63:0] r, input logic b,
                                                 input int unsigned w);
        logic [63:0] top;
        logic        divide;
        top = 64'd1 << (w - 1);
        if (b)
            r ^= top;
        divide = |(r & top);
        r = r << 1;
        if (divide)
            r ^= cfg_poly;
        return r & lane_mask(w);
    endfunction

    function automatic logic [63:0] mirror_bits(input logic [63:0] x, input int unsigned w);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < w; i++)
            if (x[i])
                r[w - 1 - i] = 1'b1;
        return r;
    endfunction

    // Fold one chunk into a remainder; also give the checksum a last chunk would report
    function automatic void crc_fold(input logic [63:0] acc, input chunk_t c,
                                     output logic [63:0] acc_next, output logic [63:0] sum);
        int unsigned w;
        int unsigned n;
        logic [63:0] m;
        w   = active_width();
        m   = lane_mask(w);
        acc = acc & m;
        if (c.first)
            acc = c.start_value & m;
        if (cfg_rin)
        begin
            for (int i = DATA_W - 1; i >= 0; i--)
                acc = shift_in_bit(acc, c.data_byte[i], w);
        end
        else
        begin
            n = (c.bit_count > DATA_W) ? DATA_W : c.bit_count;
            for (int i = 0; i < n; i++)
                acc = shift_in_bit(acc, c.data_byte[i], w);
        end
        acc_next = acc;
        sum      = ((cfg_rout ? mirror_bits(acc, w) : acc) ^ cfg_fxor) & m;
    endfunction

    // Offer one chunk, hold it until accepted, then predict. tvalid stays high afterwards.
    task automatic send_chunk(input chunk_t c, input logic pinned, input checksum_t pin);
        logic [63:0] nxt;
        logic [63:0] sum;
        checksum_t   want;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, c.check_value, c.bit_count,
                     c.data_byte, c.start_value};
        s_tuser  <= c.first;
        s_tlast  <= c.last;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        crc_fold(crc_acc, c, nxt, sum);
        crc_acc = nxt;
        if (c.last)
        begin
            want.crc_value   = sum;
            want.matches_res = (sum == c.check_value);
            checksum_q.push_back(pinned ? pin : want);
        end
    endtask

    // Write one register; cfg_valid stays high for a following write
    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_CRC_WIDTH:      cfg_crc_width = val[WIDTH_W-1:0];
            CFG_POLYNOMIAL:     cfg_poly      = val;
            CFG_FINAL_XOR:      cfg_fxor      = val;
            CFG_REFLECT_INPUT:  cfg_rin       = val[0];
            CFG_REFLECT_OUTPUT: cfg_rout      = val[0];
            default: ;
        endcase
    endtask

    // Wait for every owed checksum, then let chunks without a result clear the pipeline
    task automatic wait_drained();
        while (checksum_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Main stimulus: directed table, then phases of random messages under fresh settings
    initial
    begin
        chunk_t      c;
        logic [63:0] nxt;
        logic [63:0] sum;
        logic [63:0] junk;
        int unsigned w;
        int unsigned pick;
        int          msg_left;
        bit          opening;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings, no idling
        foreach (DIRECTED[i])
            send_chunk(DIRECTED[i].chunk, DIRECTED[i].pinned, DIRECTED[i].pin);
        s_tvalid <= 1'b0;

        msg_left = 0;
        opening  = 1'b0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();

            // Rewrite every register; junk above the field checks that only low bits count
            junk = $urandom_range(1) ? {$urandom, $urandom} : 64'h0;
            write_reg(CFG_CRC_WIDTH, {junk[63:WIDTH_W], PHASE_WIDTH[p]});
            write_reg(CFG_POLYNOMIAL, (p == 3) ? 64'h0 : (p == 5) ? {64{1'b1}}
                                                                  : {$urandom, $urandom});
            write_reg(CFG_FINAL_XOR, (p == 2) ? {64{1'b1}} : (p == 6) ? 64'h0
                                                                     : {$urandom, $urandom});
            write_reg(CFG_REFLECT_INPUT, {junk[63:1], p[0]});
            write_reg(CFG_REFLECT_OUTPUT, {junk[63:1], p[1]});
            cfg_valid <= 1'b0;

            // Rotate idling: none, sender idle, receiver stall, both
            case (p % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    rx_stall_pct    = 0;
                end
                1:
                begin
                    sender_idle_pct = 76;
                    rx_stall_pct    = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    rx_stall_pct    = 76;
                end
                default:
                begin
                    sender_idle_pct = 30;
                    rx_stall_pct    = 30;
                end
            endcase
            // Back the engine up once: receiver holds off while chunks keep coming
            if (p == 4)
                hold_go = 1'b1;

            // Messages run on across phase boundaries, so a width change can land mid-message
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (msg_left == 0)
                begin
                    msg_left = $urandom_range(1, 6);
                    opening  = 1'b1;
                end
                c.first        = opening ? ($urandom_range(99) < 92) : ($urandom_range(99) < 4);
                c.last         = (msg_left == 1) ? ($urandom_range(99) < 95)
                                                 : ($urandom_range(99) < 4);
                c.start_value  = {$urandom, $urandom};
                c.data_byte    = 8'($urandom_range(255));
                c.bit_count    = ($urandom_range(99) < 70) ? 4'd8 : 4'($urandom_range(15));
                c.check_value  = {$urandom, $urandom};
                opening  = 1'b0;
                msg_left = msg_left - 1;

                // Aim the expected value at the checksum often enough to see both flag values
                if (c.last)
                begin
                    crc_fold(crc_acc, c, nxt, sum);
                    w    = active_width();
                    pick = $urandom_range(99);
                    if (pick < 50)
                        c.check_value = sum;
                    else if (pick < 65)
                        c.check_value = sum ^ (64'd1 << $urandom_range(w - 1));
                    else if (pick < 75 && w < 64)
                        c.check_value = sum | (64'd1 << $urandom_range(63, w));
                end
                send_chunk(c, 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        if (fail_count == 0)
            $display("** configurable_crc_engine: PASSED **");
        else
            $display("** configurable_crc_engine: FAILED **");
        $finish;
    end

    // Long receiver hold-off, counted here so the sender keeps offering meanwhile
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Receiver: check each result transaction against the oldest owed checksum, then
    // pick the next cycle's ready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (checksum_q.size() == 0)
            begin
                $error("unexpected result: crc_value %h matches_res %b", m_tdata, m_tuser[0]);
                fail_count++;
            end
            else
            begin
                rx_want = checksum_q.pop_front();
                if (m_tdata !== rx_want.crc_value)
                begin
                    $error("crc_value: expected %h, got %h", rx_want.crc_value, m_tdata);
                    fail_count++;
                end
                if (m_tuser[0] !== rx_want.matches_res)
                begin
                    $error("matches_res: expected %b, got %b", rx_want.matches_res, m_tuser[0]);
                    fail_count++;
                end
            end
        end
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog: many times the slowest correct run
    initial
    begin
        #2_000_000;
        $display("** configurable_crc_engine: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/cce_pkg.sv
rtl/core/cce_feed.sv
rtl/core/configurable_crc_engine.sv
test/tb_configurable_crc_engine.sv
